>>> design/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types, operation codes and bar layout of the LED bar-graph driver.
// ----------------------------------------------------------------------------
package lsd_pkg;

    localparam int IMG_W  = 24;
    localparam int OP_W   = 3;
    localparam int LVL_W  = 8;
    localparam int IDX_W  = 5;

    localparam int DEF_IMAGE_BITS = 24;

    localparam logic [OP_W-1:0] OP_SUN         = 3'd0;
    localparam logic [OP_W-1:0] OP_ENERGY      = 3'd1;
    localparam logic [OP_W-1:0] OP_POLLUTION   = 3'd2;
    localparam logic [OP_W-1:0] OP_TEMPERATURE = 3'd3;
    localparam logic [OP_W-1:0] OP_RAW         = 3'd4;

    localparam logic [IMG_W-1:0] SUN_KEEP         = 24'h0fffff;
    localparam logic [IMG_W-1:0] ENERGY_KEEP      = 24'hf03fff;
    localparam logic [IMG_W-1:0] POLLUTION_KEEP   = 24'hffc0ff;
    localparam logic [IMG_W-1:0] TEMPERATURE_KEEP = 24'hffff00;

    localparam int SUN_SHIFT         = 20;
    localparam int ENERGY_SHIFT      = 14;
    localparam int POLLUTION_SHIFT   = 8;
    localparam int TEMPERATURE_SHIFT = 0;

    localparam logic [LVL_W-1:0] SUN_WIDTH         = 8'd4;
    localparam logic [LVL_W-1:0] ENERGY_WIDTH      = 8'd6;
    localparam logic [LVL_W-1:0] POLLUTION_WIDTH   = 8'd6;
    localparam logic [LVL_W-1:0] TEMPERATURE_WIDTH = 8'd8;

    // image handed from the front to the back through the queue
    typedef struct packed {
        logic             valid;
        logic [IMG_W-1:0] image;
    } t_img_push;

    // thermometer code: lowest min(level, width) bits set
    function automatic logic [LVL_W-1:0] therm(input logic [LVL_W-1:0] level,
                                               input logic [LVL_W-1:0] width);
        logic [LVL_W-1:0] t;
        for (int b = 0; b < LVL_W; b++) begin
            t[b] = (LVL_W'(b) < level) && (LVL_W'(b) < width);
        end
        return t;
    endfunction

endpackage

>>> design/lsd_if.sv
// ----------------------------------------------------------------------------
// lsd_if
// Valid/ready channels of the bar-graph driver: command items and serial bits.
// ----------------------------------------------------------------------------
interface lsd_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  level;
    logic [23:0] raw_image;

    modport source (output valid, operation, level, raw_image, input ready);
    modport sink   (input valid, operation, level, raw_image, output ready);
endinterface

interface lsd_out_if;
    logic        valid;
    logic        ready;
    logic        serial_bit;
    logic [4:0]  bit_index;
    logic        latch;
    logic [23:0] image;

    modport source (output valid, serial_bit, bit_index, latch, image, input ready);
    modport sink   (input valid, serial_bit, bit_index, latch, image, output ready);
endinterface

>>> design/lsd_front.sv
// ----------------------------------------------------------------------------
// lsd_front
// Accepts commands, merges the bar level into the image (or takes a raw image) and queues the image.
// ----------------------------------------------------------------------------
module lsd_front
    import lsd_pkg::*;
#(
    parameter int IMAGE_BITS = DEF_IMAGE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsd_in_if.sink        i_item,
    output t_img_push     o_push,
    input  logic          i_push_ready
);

    localparam logic [IMG_W-1:0] IMG_MASK = (IMAGE_BITS >= IMG_W) ? {IMG_W{1'b1}} :
        IMG_W'((64'd1 << IMAGE_BITS) - 64'd1);

    logic [IMG_W-1:0] r_image;
    logic [IMG_W-1:0] n_image;
    logic             op_ok;
    logic             take;
    logic [IMG_W-1:0] merged;

    always_comb begin
        op_ok  = 1'b1;
        merged = r_image;
        case (i_item.operation)
            OP_SUN: begin
                merged = (r_image & SUN_KEEP) |
                         (IMG_W'(therm(i_item.level, SUN_WIDTH)) << SUN_SHIFT);
            end
            OP_ENERGY: begin
                merged = (r_image & ENERGY_KEEP) |
                         (IMG_W'(therm(i_item.level, ENERGY_WIDTH)) << ENERGY_SHIFT);
            end
            OP_POLLUTION: begin
                merged = (r_image & POLLUTION_KEEP) |
                         (IMG_W'(therm(i_item.level, POLLUTION_WIDTH)) << POLLUTION_SHIFT);
            end
            OP_TEMPERATURE: begin
                merged = (r_image & TEMPERATURE_KEEP) |
                         (IMG_W'(therm(i_item.level, TEMPERATURE_WIDTH)) << TEMPERATURE_SHIFT);
            end
            OP_RAW: begin
                merged = i_item.raw_image;
            end
            default: begin
                // unused codes are swallowed without output
                op_ok = 1'b0;
            end
        endcase
    end

    assign i_item.ready = i_push_ready;
    assign take         = i_item.valid && i_push_ready && op_ok;
    assign n_image      = take ? (merged & IMG_MASK) : r_image;

    assign o_push.valid = take;
    assign o_push.image = merged & IMG_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image <= '0;
        end else begin
            r_image <= n_image;
        end
    end

endmodule

>>> design/lsd_queue.sv
// ----------------------------------------------------------------------------
// lsd_queue
// Two-entry image queue between command front and shift-out back.
// ----------------------------------------------------------------------------
module lsd_queue
    import lsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_img_push        i_push,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output logic [IMG_W-1:0] o_pop_image,
    input  logic             i_pop_ready
);

    logic [IMG_W-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_image  = r_mem[r_rp];

    assign push = i_push.valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.image;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count did not follow push");

    a_ptr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers disagree with count");

endmodule

>>> design/lsd_shifter.sv
// ----------------------------------------------------------------------------
// lsd_shifter
// Shifts one queued image out LSB first as inverted serial bit items.
// ----------------------------------------------------------------------------
module lsd_shifter
    import lsd_pkg::*;
#(
    parameter int IMAGE_BITS = DEF_IMAGE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic [IMG_W-1:0] i_q_image,
    output logic             o_q_ready,
    lsd_out_if.source        o_result
);

    localparam int CNT_W = $clog2(IMAGE_BITS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(IMAGE_BITS - 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_idx;
    logic [IMG_W-1:0] r_sh;
    logic [IMG_W-1:0] r_image;
    logic             last;
    logic             fire;
    logic             load;

    assign last = (r_idx == LAST);
    assign fire = o_result.valid && o_result.ready;
    // refill from the queue on the cycle the latch bit leaves
    assign o_q_ready = !r_busy || (o_result.ready && last);
    assign load      = i_q_valid && o_q_ready;

    assign o_result.valid      = r_busy;
    // zero fill past bit 23 gives ones on the line
    assign o_result.serial_bit = ~r_sh[0];
    assign o_result.bit_index  = IDX_W'(r_idx);
    assign o_result.latch      = last;
    assign o_result.image      = r_image;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sh    <= i_q_image;
            r_image <= i_q_image;
        end else if (fire) begin
            r_sh <= r_sh >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fire) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= LAST)
        else $error("bit index past last bit");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !last |=> o_result.valid &&
            o_result.bit_index == $past(o_result.bit_index) + 5'd1)
        else $error("bit index did not advance");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && last && !i_q_valid |=> !o_result.valid)
        else $error("shifter stayed busy after latch bit");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && last && i_q_valid |=> o_result.valid && o_result.bit_index == 5'd0)
        else $error("shifter did not restart on next image");

endmodule

>>> design/led_bargraph_shift_driver.sv
// ----------------------------------------------------------------------------
// led_bargraph_shift_driver
// Four LED bar graphs kept as one image and shifted out serially per update.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  i_item    in   valid/ready          operation, level, raw_image
//  o_result  out  valid/ready          serial_bit, bit_index, latch, image
//
//  One command yields IMAGE_BITS bit items, one per cycle when o_result is
//  ready; the shift counter in the back part sets this rate.
//  Commands enter at one per cycle while the two-entry image queue has room.
//  Unused operation codes are taken and produce no items.
//  Synchronous active-low reset clears the image and empties the queue.
// ----------------------------------------------------------------------------
module led_bargraph_shift_driver
    import lsd_pkg::*;
#(
    parameter int IMAGE_BITS = DEF_IMAGE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsd_in_if.sink    i_item,
    lsd_out_if.source o_result
);

    t_img_push        push;
    logic             push_ready;
    logic             pop_valid;
    logic [IMG_W-1:0] pop_image;
    logic             pop_ready;

    lsd_front #(
        .IMAGE_BITS (IMAGE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    lsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_image  (pop_image),
        .i_pop_ready  (pop_ready)
    );

    lsd_shifter #(
        .IMAGE_BITS (IMAGE_BITS)
    ) u_shifter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .i_q_image (pop_image),
        .o_q_ready (pop_ready),
        .o_result  (o_result)
    );

endmodule

>>> tb/lsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_checker
// Watches the command and bit channels of the bar-graph driver. Keeps its own
// copy of the LED image, predicts the serial bits of every accepted command,
// and compares each bit item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lsd_checker
    import lsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lsd_in_if    i_item,
    lsd_out_if   i_result,
    output int   o_mismatches,
    output int   o_pending
);

    typedef struct packed {
        logic             serial_bit;
        logic [IDX_W-1:0] bit_index;
        logic             latch;
        logic [IMG_W-1:0] image;
    } t_shift_bit;

    logic [IMG_W-1:0] led_image;
    logic [IMG_W-1:0] next_image;
    logic             image_changed;
    t_shift_bit       shift_bits_due[$];
    t_shift_bit       seen_bit;
    t_shift_bit       due_bit;
    int               mismatch_count = 0;

    // lowest min(level, width) LEDs of one bar, placed at the bar's offset
    function automatic logic [IMG_W-1:0] lit_leds(input logic [LVL_W-1:0] level,
                                                  input logic [LVL_W-1:0] width,
                                                  input int unsigned offset);
        logic [LVL_W-1:0] lit;
        logic [31:0]      code;
        lit  = (level > width) ? width : level;
        code = ((32'd1 << lit) - 32'd1) << offset;
        return code[IMG_W-1:0];
    endfunction

    function automatic logic apply_command(input  logic [OP_W-1:0]  op,
                                           input  logic [LVL_W-1:0] level,
                                           input  logic [IMG_W-1:0] raw,
                                           input  logic [IMG_W-1:0] cur,
                                           output logic [IMG_W-1:0] img);
        logic live;
        live = 1'b1;
        img  = cur;
        case (op)
            OP_SUN: begin
                img = (cur & SUN_KEEP) | lit_leds(level, SUN_WIDTH, SUN_SHIFT);
            end
            OP_ENERGY: begin
                img = (cur & ENERGY_KEEP) | lit_leds(level, ENERGY_WIDTH, ENERGY_SHIFT);
            end
            OP_POLLUTION: begin
                img = (cur & POLLUTION_KEEP)
                    | lit_leds(level, POLLUTION_WIDTH, POLLUTION_SHIFT);
            end
            OP_TEMPERATURE: begin
                img = (cur & TEMPERATURE_KEEP)
                    | lit_leds(level, TEMPERATURE_WIDTH, TEMPERATURE_SHIFT);
            end
            OP_RAW: begin
                img = raw;
            end
            default: begin
                live = 1'b0;
            end
        endcase
        return live;
    endfunction

    task automatic report_field(input string name, input logic [IMG_W-1:0] exp_val,
                                input logic [IMG_W-1:0] act_val);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                 $time, name, exp_val, act_val);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            led_image = '0;
            shift_bits_due.delete();
        end else begin
            // queue the prediction first so a same-edge result still finds it
            if (i_item.valid && i_item.ready) begin
                image_changed = apply_command(i_item.operation, i_item.level,
                                              i_item.raw_image, led_image, next_image);
                if (image_changed) begin
                    led_image = next_image;
                    for (int b = 0; b < DEF_IMAGE_BITS; b++) begin
                        due_bit.serial_bit = ~next_image[b];
                        due_bit.bit_index  = IDX_W'(b);
                        due_bit.latch      = (b == DEF_IMAGE_BITS - 1);
                        due_bit.image      = next_image;
                        shift_bits_due.push_back(due_bit);
                    end
                end
            end
            if (i_result.valid && i_result.ready) begin
                seen_bit.serial_bit = i_result.serial_bit;
                seen_bit.bit_index  = i_result.bit_index;
                seen_bit.latch      = i_result.latch;
                seen_bit.image      = i_result.image;
                if (shift_bits_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected bit item, expected none, actual %0h",
                             $time, seen_bit);
                end else begin
                    due_bit = shift_bits_due.pop_front();
                    if (seen_bit.serial_bit !== due_bit.serial_bit)
                        report_field("serial_bit", IMG_W'(due_bit.serial_bit),
                                     IMG_W'(seen_bit.serial_bit));
                    if (seen_bit.bit_index !== due_bit.bit_index)
                        report_field("bit_index", IMG_W'(due_bit.bit_index),
                                     IMG_W'(seen_bit.bit_index));
                    if (seen_bit.latch !== due_bit.latch)
                        report_field("latch", IMG_W'(due_bit.latch),
                                     IMG_W'(seen_bit.latch));
                    if (seen_bit.image !== due_bit.image)
                        report_field("image", due_bit.image, seen_bit.image);
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= shift_bits_due.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bar-level, raw-image and unused-code commands into the bar-graph driver with
// random gaps and output stalls, including one long output hold that backs
// up the command queue. The checker predicts and compares the bit items.
// ----------------------------------------------------------------------------
module testbench
    import lsd_pkg::*;
;

    localparam int RANDOM_ITEMS  = 200;
    localparam int LONG_HOLD     = 150;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PRESSURE_AT   = 60;
    localparam int PRESSURE_LEN  = 12;
    localparam int QUIET_FROM    = 160;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    bit   sender_idles   = 1'b1;
    bit   receiver_idles = 1'b1;
    bit   long_hold      = 1'b0;

    lsd_in_if  cmd_ch ();
    lsd_out_if bit_ch ();

    led_bargraph_shift_driver dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (cmd_ch),
        .o_result (bit_ch)
    );

    lsd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (cmd_ch),
        .i_result     (bit_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [LVL_W-1:0] level,
                            input logic [IMG_W-1:0] raw);
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.level     <= level;
        cmd_ch.raw_image <= raw;
        do @(posedge clk); while (!cmd_ch.ready);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // bit item receiver: random stall bursts plus one long hold on request
    initial begin
        bit_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (long_hold) begin
                bit_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
                bit_ch.ready <= 1'b1;
                @(posedge clk);
            end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
                bit_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                bit_ch.ready <= 1'b1;
                @(posedge clk);
            end else begin
                bit_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        int               live_sent;
        bit               pressure_done;
        logic [OP_W-1:0]  op;
        logic [LVL_W-1:0] level;
        logic [IMG_W-1:0] raw;

        live_sent     = 0;
        pressure_done = 1'b0;
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= OP_SUN;
        cmd_ch.level     <= '0;
        cmd_ch.raw_image <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bar extremes: cleared, exactly full, saturated past the bar width
        send_cmd(OP_SUN, 8'd0, 24'h000000);
        send_cmd(OP_SUN, 8'd4, 24'hffffff);
        send_cmd(OP_SUN, 8'd255, 24'h000000);
        send_cmd(OP_SUN, 8'd3, 24'h5a5a5a);
        send_cmd(OP_ENERGY, 8'd0, 24'h000000);
        send_cmd(OP_ENERGY, 8'd6, 24'h000000);
        send_cmd(OP_ENERGY, 8'd7, 24'h000000);
        send_cmd(OP_ENERGY, 8'd200, 24'h000000);
        send_cmd(OP_POLLUTION, 8'd0, 24'h000000);
        send_cmd(OP_POLLUTION, 8'd6, 24'h000000);
        send_cmd(OP_POLLUTION, 8'd128, 24'h000000);
        send_cmd(OP_POLLUTION, 8'd1, 24'h000000);
        send_cmd(OP_TEMPERATURE, 8'd0, 24'h000000);
        send_cmd(OP_TEMPERATURE, 8'd8, 24'h000000);
        send_cmd(OP_TEMPERATURE, 8'd9, 24'h000000);
        send_cmd(OP_TEMPERATURE, 8'd255, 24'h000000);
        send_cmd(OP_TEMPERATURE, 8'd5, 24'h000000);
        send_cmd(OP_RAW, 8'd0, 24'h000000);
        send_cmd(OP_RAW, 8'd255, 24'hffffff);
        send_cmd(OP_RAW, 8'd0, 24'ha5a5a5);
        // unused codes leave the image alone and produce no bit items
        send_cmd(OP_RAW + OP_W'(1), 8'd255, 24'hffffff);
        send_cmd(OP_RAW + OP_W'(2), 8'd0, 24'h000000);
        send_cmd(OP_RAW + OP_W'(3), 8'd17, 24'h123456);
        send_cmd(OP_TEMPERATURE, 8'd2, 24'h000000);
        send_cmd(OP_RAW, 8'd0, 24'h5a5a5a);

        while (live_sent < RANDOM_ITEMS) begin
            if (live_sent == PRESSURE_AT && !pressure_done) begin
                pressure_done = 1'b1;
                long_hold     = 1'b1;
                sender_idles  = 1'b0;
            end
            if (live_sent == PRESSURE_AT + PRESSURE_LEN)
                sender_idles = 1'b1;
            if (live_sent >= QUIET_FROM) begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            level = ($urandom_range(0, 3) == 0) ? LVL_W'($urandom_range(0, 255))
                                                : LVL_W'($urandom_range(0, 10));
            raw   = IMG_W'($urandom());
            case ($urandom_range(0, 19))
                0: begin
                    op = OP_RAW + OP_W'($urandom_range(1, 3));
                end
                1, 2, 3: begin
                    op = OP_RAW;
                    live_sent++;
                end
                4, 5, 6, 7: begin
                    op = OP_SUN;
                    live_sent++;
                end
                8, 9, 10, 11: begin
                    op = OP_ENERGY;
                    live_sent++;
                end
                12, 13, 14, 15: begin
                    op = OP_POLLUTION;
                    live_sent++;
                end
                default: begin
                    op = OP_TEMPERATURE;
                    live_sent++;
                end
            endcase
            send_cmd(op, level, raw);
        end
        cmd_ch.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
